>>> rtl/fmrt_pkg.sv
`timescale 1ns / 1ps
package fmrt_pkg;

  localparam int unsigned NUM_RULES_DEF   = 64;
  localparam int unsigned ACTION_BITS_DEF = 32;
  localparam int unsigned IDX_W           = 8;
  localparam int unsigned MASK_W          = 32;
  localparam int unsigned WORD_W          = 32;
  localparam int unsigned HIT_IDX_W       = 6;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  // Request plus the result it collects while walking the cell chain
  typedef struct packed {
    mode_t               mode;
    logic [IDX_W-1:0]    idx;
    logic [MASK_W-1:0]   rule_mask;
    logic [WORD_W-1:0]   rule_action;
    logic [MASK_W-1:0]   packet_mask;
    logic                search;
    logic                status;
    logic                hit;
    logic [IDX_W-1:0]    hit_index;
    logic                entry_valid;
    logic [MASK_W-1:0]   entry_mask;
    logic [WORD_W-1:0]   action;
  } tok_t;

endpackage

>>> rtl/fmrt_if.sv
`timescale 1ns / 1ps
interface fmrt_in_if;
  logic                         valid;
  logic                         ready;
  fmrt_pkg::mode_t              mode;
  logic [fmrt_pkg::IDX_W-1:0]   rule_index;
  logic [fmrt_pkg::MASK_W-1:0]  rule_mask;
  logic [fmrt_pkg::WORD_W-1:0]  rule_action;
  logic [fmrt_pkg::MASK_W-1:0]  packet_mask;

  modport source (output valid, mode, rule_index, rule_mask, rule_action, packet_mask,
                  input ready);
  modport sink (input valid, mode, rule_index, rule_mask, rule_action, packet_mask,
                output ready);
endinterface

interface fmrt_out_if;
  logic                           valid;
  logic                           ready;
  logic                           status;
  logic                           hit;
  logic [fmrt_pkg::HIT_IDX_W-1:0] hit_index;
  logic                           entry_valid;
  logic [fmrt_pkg::MASK_W-1:0]    entry_mask;
  logic [fmrt_pkg::WORD_W-1:0]    action_out;

  modport source (output valid, status, hit, hit_index, entry_valid, entry_mask, action_out,
                  input ready);
  modport sink (input valid, status, hit, hit_index, entry_valid, entry_mask, action_out,
                output ready);
endinterface

>>> rtl/fmrt_cell.sv
`timescale 1ns / 1ps
module fmrt_cell #(
  parameter int unsigned CELL_IDX    = 0,
  parameter int unsigned ACTION_BITS = fmrt_pkg::ACTION_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            act_i,
  input  fmrt_pkg::tok_t  tok_i,
  output logic            act_o,
  output fmrt_pkg::tok_t  tok_o
);

  // Action bits above the input word are always zero, so keep at most one word
  localparam int unsigned AW = (ACTION_BITS < fmrt_pkg::WORD_W) ? ACTION_BITS
                                                                : fmrt_pkg::WORD_W;

  logic                          vld_r;
  logic [fmrt_pkg::MASK_W-1:0]   mask_r;
  logic [AW-1:0]                 act_r;
  logic                          act_o_r;
  fmrt_pkg::tok_t                tok_o_r;
  fmrt_pkg::tok_t                tok_nxt;
  logic                          sel;
  logic                          match;
  logic [fmrt_pkg::MASK_W-1:0]   mask_rd;
  logic [fmrt_pkg::WORD_W-1:0]   act_rd;

  assign sel     = (tok_i.idx == fmrt_pkg::IDX_W'(CELL_IDX));
  // An empty entry reads as zero
  assign mask_rd = vld_r ? mask_r : '0;
  assign act_rd  = vld_r ? fmrt_pkg::WORD_W'(act_r) : '0;
  assign match   = tok_i.search && !tok_i.hit && vld_r &&
                   ((mask_r & tok_i.packet_mask) == mask_r);

  always_comb begin
    tok_nxt = tok_i;
    if (match) begin
      tok_nxt.hit       = 1'b1;
      tok_nxt.hit_index = fmrt_pkg::IDX_W'(CELL_IDX);
      tok_nxt.action    = act_rd;
    end
    if (sel && tok_i.mode == fmrt_pkg::MODE_READ) begin
      tok_nxt.entry_valid = vld_r;
      tok_nxt.entry_mask  = mask_rd;
      tok_nxt.action      = act_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      act_o_r <= 1'b0;
    end else begin
      act_o_r <= act_i;
      if (act_i && sel) begin
        case (tok_i.mode)
          fmrt_pkg::MODE_ADD:    vld_r <= 1'b1;
          fmrt_pkg::MODE_DELETE: vld_r <= 1'b0;
          default:               vld_r <= vld_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_o_r <= tok_nxt;
    if (act_i && sel && tok_i.mode == fmrt_pkg::MODE_ADD) begin
      mask_r <= tok_i.rule_mask;
      act_r  <= tok_i.rule_action[AW-1:0];
    end
  end

  assign act_o = act_o_r;
  assign tok_o = tok_o_r;

endmodule

>>> rtl/first_match_mask_rule_table.sv
`timescale 1ns / 1ps
// A result is valid once the request has passed the head register, the NUM_RULES
// cell registers and the result register. One item at a time: the next input is
// taken the cycle after the result transfers. A request walks the rule cell chain
// one cell per cycle.
// Reset (synchronous, active low) clears every rule's valid bit at once.
module first_match_mask_rule_table #(
  parameter int unsigned NUM_RULES   = fmrt_pkg::NUM_RULES_DEF,
  parameter int unsigned ACTION_BITS = fmrt_pkg::ACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  fmrt_in_if.sink     in_ch,
  fmrt_out_if.source  out_ch
);

  logic                 busy_r;
  logic                 head_act_r;
  fmrt_pkg::tok_t       head_tok_r;
  fmrt_pkg::tok_t       head_tok_nxt;
  logic                 out_valid_r;
  fmrt_pkg::tok_t       out_tok_r;
  logic                 chain_act [NUM_RULES+1];
  fmrt_pkg::tok_t       chain_tok [NUM_RULES+1];
  logic [NUM_RULES:0]   act_vec;
  logic                 in_xfer;
  logic                 out_xfer;

  assign in_ch.ready = !busy_r;
  assign in_xfer     = in_ch.valid && !busy_r;
  assign out_xfer    = out_valid_r && out_ch.ready;

  always_comb begin
    head_tok_nxt             = '0;
    head_tok_nxt.mode        = in_ch.mode;
    head_tok_nxt.idx         = in_ch.rule_index;
    head_tok_nxt.rule_mask   = in_ch.rule_mask;
    head_tok_nxt.rule_action = in_ch.rule_action;
    head_tok_nxt.packet_mask = in_ch.packet_mask;
    head_tok_nxt.search      = (in_ch.mode == fmrt_pkg::MODE_LOOKUP) &&
                               (in_ch.packet_mask != '0);
    head_tok_nxt.status      = (in_ch.mode != fmrt_pkg::MODE_LOOKUP) &&
                               ({1'b0, in_ch.rule_index} >= (fmrt_pkg::IDX_W+1)'(NUM_RULES));
    // A bad index must not touch any cell
    if (head_tok_nxt.status) begin
      head_tok_nxt.mode = fmrt_pkg::MODE_LOOKUP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      head_act_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_act_r <= in_xfer;
      if (in_xfer) begin
        busy_r <= 1'b1;
      end else if (out_xfer) begin
        busy_r <= 1'b0;
      end
      if (chain_act[NUM_RULES]) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      head_tok_r <= head_tok_nxt;
    end
    if (chain_act[NUM_RULES]) begin
      out_tok_r <= chain_tok[NUM_RULES];
    end
  end

  assign chain_act[0] = head_act_r;
  assign chain_tok[0] = head_tok_r;

  for (genvar g = 0; g < NUM_RULES; g++) begin : g_cell
    fmrt_cell #(
      .CELL_IDX    (g),
      .ACTION_BITS (ACTION_BITS)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .act_i (chain_act[g]),
      .tok_i (chain_tok[g]),
      .act_o (chain_act[g+1]),
      .tok_o (chain_tok[g+1])
    );
  end

  for (genvar g = 0; g <= NUM_RULES; g++) begin : g_act_vec
    assign act_vec[g] = chain_act[g];
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_tok_r.status;
  assign out_ch.hit         = out_tok_r.hit;
  assign out_ch.hit_index   = out_tok_r.hit_index[fmrt_pkg::HIT_IDX_W-1:0];
  assign out_ch.entry_valid = out_tok_r.entry_valid;
  assign out_ch.entry_mask  = out_tok_r.entry_mask;
  assign out_ch.action_out  = out_tok_r.action;

  // At most one request walks the chain
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(act_vec))
    else $error("more than one request in the cell chain");

  // Chain never lands a result on top of one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    chain_act[NUM_RULES] |-> !out_valid_r)
    else $error("result register overwritten");

  // Nothing is taken while a request is outstanding
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ch.ready)
    else $error("input taken while busy");

  // Once the result leaves, the block is free again
  a_free_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |=> in_ch.ready && !out_valid_r)
    else $error("block not released after result transfer");

  // A request in the chain always means the block is busy
  a_busy_cover: assert property (@(posedge clk) disable iff (!rst_n)
    (act_vec != '0) |-> busy_r && !out_valid_r)
    else $error("request in flight while idle");

endmodule

>>> sim/first_match_mask_rule_table_tb.sv
`timescale 1ns / 1ps
module first_match_mask_rule_table_tb;

  localparam int unsigned RULES    = fmrt_pkg::NUM_RULES_DEF;
  localparam int unsigned N_RANDOM = 1580;
  localparam int unsigned N_QUIET  = 150;
  localparam int unsigned HOLD_LEN = 400;
  localparam logic [fmrt_pkg::WORD_W-1:0] ACTION_KEEP =
    {fmrt_pkg::WORD_W{1'b1}} >> (fmrt_pkg::WORD_W - fmrt_pkg::ACTION_BITS_DEF);
  localparam bit TYPED   = 1'b1;
  localparam bit PREDICT = 1'b0;

  typedef struct packed {
    fmrt_pkg::mode_t             mode;
    logic [fmrt_pkg::IDX_W-1:0]  idx;
    logic [fmrt_pkg::MASK_W-1:0] rule_mask;
    logic [fmrt_pkg::WORD_W-1:0] rule_action;
    logic [fmrt_pkg::MASK_W-1:0] packet_mask;
  } request_t;

  typedef struct packed {
    logic                           status;
    logic                           hit;
    logic [fmrt_pkg::HIT_IDX_W-1:0] hit_index;
    logic                           entry_valid;
    logic [fmrt_pkg::MASK_W-1:0]    entry_mask;
    logic [fmrt_pkg::WORD_W-1:0]    action;
  } reply_t;

  typedef struct {
    request_t req;
    bit       typed;
    reply_t   want;
  } step_t;

  localparam reply_t REPLY_ZERO      = '0;
  localparam reply_t REPLY_BAD_INDEX = '{status: 1'b1, default: '0};

  logic clk;
  logic rst_n;

  fmrt_in_if  in_ch ();
  fmrt_out_if out_ch ();

  first_match_mask_rule_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the rule table
  logic                        tbl_valid  [RULES];
  logic [fmrt_pkg::MASK_W-1:0] tbl_mask   [RULES];
  logic [fmrt_pkg::WORD_W-1:0] tbl_action [RULES];
  int unsigned                 tbl_top;

  reply_t      replies_due[$];
  step_t       steps[$];
  int unsigned n_sent;
  int unsigned n_fail;
  bit          quiet;
  bit          hold_off;
  int unsigned gap_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("first_match_mask_rule_table test failed");
    $finish;
  end

  function automatic reply_t apply_request(request_t r);
    reply_t res;
    int     i;
    res = '0;
    if (r.mode == fmrt_pkg::MODE_LOOKUP) begin
      if (r.packet_mask != '0) begin
        for (i = 0; i < int'(tbl_top); i++) begin
          if (tbl_valid[i] && (tbl_mask[i] & r.packet_mask) == tbl_mask[i]) begin
            res.hit       = 1'b1;
            res.hit_index = fmrt_pkg::HIT_IDX_W'(i);
            res.action    = tbl_action[i];
            break;
          end
        end
      end
    end else if (r.idx >= RULES) begin
      res.status = 1'b1;
    end else if (r.mode == fmrt_pkg::MODE_ADD) begin
      tbl_valid[r.idx]  = 1'b1;
      tbl_mask[r.idx]   = r.rule_mask;
      tbl_action[r.idx] = r.rule_action & ACTION_KEEP;
      if (r.idx >= tbl_top) tbl_top = r.idx + 1;
    end else if (r.mode == fmrt_pkg::MODE_DELETE) begin
      tbl_valid[r.idx]  = 1'b0;
      tbl_mask[r.idx]   = '0;
      tbl_action[r.idx] = '0;
    end else begin
      res.entry_valid = tbl_valid[r.idx];
      res.entry_mask  = tbl_mask[r.idx];
      res.action      = tbl_action[r.idx];
    end
    return res;
  endfunction

  function automatic step_t row(fmrt_pkg::mode_t m, logic [fmrt_pkg::IDX_W-1:0] i,
                                logic [fmrt_pkg::MASK_W-1:0] rm,
                                logic [fmrt_pkg::WORD_W-1:0] ra,
                                logic [fmrt_pkg::MASK_W-1:0] pm,
                                bit typed, reply_t want);
    step_t s;
    s.req   = '{m, i, rm, ra, pm};
    s.typed = typed;
    s.want  = want;
    return s;
  endfunction

  function automatic logic [fmrt_pkg::MASK_W-1:0] sparse_bits();
    return $urandom & $urandom & $urandom;
  endfunction

  function automatic int unsigned idle_rate();
    case ($urandom_range(0, 3))
      0, 1:    return 0;
      2:       return 8;
      default: return 30;
    endcase
  endfunction

  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 10)      r.idx = fmrt_pkg::IDX_W'($urandom_range(RULES, 255));
    else if (pick < 40) r.idx = fmrt_pkg::IDX_W'($urandom_range(0, 15));
    else                r.idx = fmrt_pkg::IDX_W'($urandom_range(0, RULES - 1));
    r.rule_action = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 5)       r.rule_mask = '0;
    else if (pick < 15) r.rule_mask = $urandom;
    else if (pick < 30) r.rule_mask = 32'h1 << $urandom_range(0, 31);
    else                r.rule_mask = sparse_bits();
    // Build many packet masks around stored rules so lookups hit deep in the table
    pick = $urandom_range(0, 99);
    if (pick < 5)       r.packet_mask = '0;
    else if (pick < 10) r.packet_mask = '1;
    else if (pick < 55) r.packet_mask = tbl_mask[$urandom_range(0, RULES - 1)] | sparse_bits();
    else                r.packet_mask = $urandom | $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 45)      r.mode = fmrt_pkg::MODE_LOOKUP;
    else if (pick < 72) r.mode = fmrt_pkg::MODE_ADD;
    else if (pick < 84) r.mode = fmrt_pkg::MODE_DELETE;
    else                r.mode = fmrt_pkg::MODE_READ;
    return r;
  endfunction

  task automatic offer(request_t r, bit typed, reply_t want);
    reply_t predicted;
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= r.mode;
    in_ch.rule_index  <= r.idx;
    in_ch.rule_mask   <= r.rule_mask;
    in_ch.rule_action <= r.rule_action;
    in_ch.packet_mask <= r.packet_mask;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = apply_request(r);
    replies_due.push_back(typed ? want : predicted);
    n_sent++;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.mode        <= fmrt_pkg::MODE_LOOKUP;
    in_ch.rule_index  <= '0;
    in_ch.rule_mask   <= '0;
    in_ch.rule_action <= '0;
    in_ch.packet_mask <= '0;
    for (int i = 0; i < RULES; i++) begin
      tbl_valid[i]  = 1'b0;
      tbl_mask[i]   = '0;
      tbl_action[i] = '0;
    end
    tbl_top = 0;
    n_sent  = 0;
    n_fail  = 0;
    quiet   = 1'b0;
    gap_pct = 0;

    //                  mode                   idx     rule_mask      action
    //                  packet_mask
    steps.push_back(row(fmrt_pkg::MODE_LOOKUP, 8'd0,   32'h0,         32'h0,
                        32'hFFFF_FFFF, TYPED, REPLY_ZERO));
    steps.push_back(row(fmrt_pkg::MODE_READ,   8'd0,   32'h0,         32'h0,
                        32'h0, TYPED, REPLY_ZERO));
    steps.push_back(row(fmrt_pkg::MODE_READ,   8'd255, 32'h0,         32'h0,
                        32'h0, TYPED, REPLY_BAD_INDEX));
    steps.push_back(row(fmrt_pkg::MODE_ADD,    8'd64,  32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'h0, TYPED, REPLY_BAD_INDEX));
    steps.push_back(row(fmrt_pkg::MODE_DELETE, 8'd200, 32'h0,         32'h0,
                        32'h0, TYPED, REPLY_BAD_INDEX));
    steps.push_back(row(fmrt_pkg::MODE_ADD,    8'd5,   32'h0000_00F0, 32'hDEAD_BEEF,
                        32'h0, TYPED, REPLY_ZERO));
    steps.push_back(row(fmrt_pkg::MODE_LOOKUP, 8'd0,   32'h0,         32'h0,
                        32'h0, TYPED, REPLY_ZERO));
    steps.push_back(row(fmrt_pkg::MODE_LOOKUP, 8'd0,   32'h0,         32'h0,
                        32'h0000_00F0, PREDICT, REPLY_ZERO));
    steps.push_back(row(fmrt_pkg::MODE_LOOKUP, 8'd0,   32'h0,         32'h0,
                        32'h0000_0070, PREDICT, REPLY_ZERO));
    // empty mask at the top entry matches any nonzero packet
    steps.push_back(row(fmrt_pkg::MODE_ADD,    8'd63,  32'h0,         32'hFFFF_FFFF,
                        32'h0, TYPED, REPLY_ZERO));
    steps.push_back(row(fmrt_pkg::MODE_LOOKUP, 8'd0,   32'h0,         32'h0,
                        32'h0000_0001, PREDICT, REPLY_ZERO));
    steps.push_back(row(fmrt_pkg::MODE_LOOKUP, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'h0, TYPED, REPLY_ZERO));
    steps.push_back(row(fmrt_pkg::MODE_ADD,    8'd0,   32'hFFFF_FFFF, 32'h0,
                        32'h0, TYPED, REPLY_ZERO));
    steps.push_back(row(fmrt_pkg::MODE_LOOKUP, 8'd0,   32'h0,         32'h0,
                        32'hFFFF_FFFF, PREDICT, REPLY_ZERO));
    steps.push_back(row(fmrt_pkg::MODE_READ,   8'd0,   32'h0,         32'h0,
                        32'h0, PREDICT, REPLY_ZERO));
    steps.push_back(row(fmrt_pkg::MODE_READ,   8'd63,  32'h0,         32'h0,
                        32'h0, PREDICT, REPLY_ZERO));
    steps.push_back(row(fmrt_pkg::MODE_DELETE, 8'd0,   32'h0,         32'h0,
                        32'h0, TYPED, REPLY_ZERO));
    steps.push_back(row(fmrt_pkg::MODE_LOOKUP, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF, PREDICT, REPLY_ZERO));
    steps.push_back(row(fmrt_pkg::MODE_DELETE, 8'd63,  32'h0,         32'h0,
                        32'h0, TYPED, REPLY_ZERO));
    steps.push_back(row(fmrt_pkg::MODE_READ,   8'd63,  32'h0,         32'h0,
                        32'h0, TYPED, REPLY_ZERO));
    // high-water count stays up after the delete
    steps.push_back(row(fmrt_pkg::MODE_LOOKUP, 8'd0,   32'h0,         32'h0,
                        32'h0000_0001, PREDICT, REPLY_ZERO));
    steps.push_back(row(fmrt_pkg::MODE_READ,   8'd64,  32'h0,         32'h0,
                        32'h0, TYPED, REPLY_BAD_INDEX));
    steps.push_back(row(fmrt_pkg::MODE_ADD,    8'd5,   32'hAAAA_AAAA, 32'h5555_5555,
                        32'h0, TYPED, REPLY_ZERO));
    steps.push_back(row(fmrt_pkg::MODE_LOOKUP, 8'd0,   32'h0,         32'h0,
                        32'hAAAA_AAAA, PREDICT, REPLY_ZERO));
    steps.push_back(row(fmrt_pkg::MODE_ADD,    8'd255, 32'h1234_5678, 32'h8765_4321,
                        32'h0, TYPED, REPLY_BAD_INDEX));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (steps[k]) offer(steps[k].req, steps[k].typed, steps[k].want);
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == N_RANDOM - N_QUIET) quiet = 1'b1;
      if (k % 32 == 0) gap_pct = idle_rate();
      offer(random_request(), PREDICT, REPLY_ZERO);
    end
    in_ch.valid <= 1'b0;

    while (replies_due.size() != 0) @(posedge clk);
    repeat (2 * RULES + 4) @(posedge clk);
    if (n_fail == 0 && replies_due.size() == 0) begin
      $display("first_match_mask_rule_table test passed");
    end else begin
      $display("first_match_mask_rule_table test failed");
    end
    $finish;
  end

  // Result side: random stall bursts, plus the long hold-off below
  initial begin
    int unsigned stall_left;
    int unsigned stall_pct;
    int unsigned tick;
    stall_left = 0;
    stall_pct  = 0;
    tick       = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (tick % 64 == 0) stall_pct = idle_rate();
      tick++;
      if (stall_left == 0 && !quiet && $urandom_range(0, 99) < stall_pct)
        stall_left = $urandom_range(1, 15);
      if (hold_off || stall_left != 0) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
      if (stall_left != 0) stall_left--;
      @(posedge clk);
    end
  end

  // Hold the result side off long enough that the input backs up
  initial begin
    hold_off = 1'b0;
    wait (n_sent >= 120);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.status, out_ch.hit, out_ch.hit_index, out_ch.entry_valid,
              out_ch.entry_mask, out_ch.action_out};
      if (replies_due.size() == 0) begin
        n_fail++;
        if (n_fail <= 10) $display("%0t: result with nothing pending: %p", $realtime, got);
      end else begin
        want = replies_due.pop_front();
        if (got.status !== want.status || got.hit !== want.hit ||
            got.hit_index !== want.hit_index || got.entry_valid !== want.entry_valid ||
            got.entry_mask !== want.entry_mask || got.action !== want.action) begin
          n_fail++;
          if (n_fail <= 10) begin
            $display("%0t: mismatch exp st=%0d hit=%0d idx=%0d ev=%0d mask=%h act=%h",
                     $realtime, want.status, want.hit, want.hit_index, want.entry_valid,
                     want.entry_mask, want.action);
            $display("%0t:          got st=%0d hit=%0d idx=%0d ev=%0d mask=%h act=%h",
                     $realtime, got.status, got.hit, got.hit_index, got.entry_valid,
                     got.entry_mask, got.action);
          end
        end
      end
    end
  end

endmodule
